// ----- hw/rtl/lbbc_pkg.sv -----
// Shared types and constants for the block buffer cache tag manager.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package lbbc_pkg;

   localparam int SLOT_W  = 5;
   localparam int COUNT_W = 8;
   localparam int DEV_W   = 8;
   localparam int BLK_W   = 32;
   localparam int TIME_W  = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef enum logic [1:0] {
      MODE_GET     = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_PIN     = 2'd2,
      MODE_UNPIN   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_UNDER   = 2'd2,
      ST_OVER    = 2'd3
   } status_type;

   typedef struct packed {
      mode_type          mode;
      logic [DEV_W-1:0]  device;
      logic [BLK_W-1:0]  block_number;
      logic [SLOT_W-1:0] slot_in;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_out;
      logic              hit;
      logic              needs_read;
      status_type        status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic scan_rd;
      logic slot_rd;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lru_block_buffer_cache_core.sv -----
// Top level of the block buffer cache tag manager.
// Depends on lbbc_pkg, lbbc_controller and lbbc_datapath.
//
//   Channel   Ports                            Payload
//   request   req_valid, req_ready, req_data   lbbc_pkg::req_type
//   response  rsp_valid, rsp_ready, rsp_data   lbbc_pkg::rsp_type
//
// A get runs the scan, which reads one slot per cycle from the tag, count and last-use
// memories, and then one update.
// Release, pin and unpin run one memory read and one update.
// Reset is synchronous and clears per-slot valid bits, so no clearing pass runs.
// A new beat is accepted while the previous response waits; the update stalls
// only when the response register is still full.
`default_nettype none

module lru_block_buffer_cache_core #(
   parameter int SLOT_COUNT = 32
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  lbbc_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output lbbc_pkg::rsp_type  rsp_data
);

   lbbc_pkg::cmd_type cmd;
   lbbc_pkg::sts_type sts;
   logic              req_is_get;

   assign req_is_get = (req_data.mode == lbbc_pkg::MODE_GET);

   lbbc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_is_get (req_is_get),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   lbbc_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/lbbc_datapath.sv -----
// Datapath: slot memories, scan comparators, update logic and response register.
// Depends on lbbc_pkg; driven by lbbc_controller through cmd_type commands.
`default_nettype none

module lbbc_datapath #(
   parameter int SLOT_COUNT = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  lbbc_pkg::cmd_type      cmd,
   output lbbc_pkg::sts_type      sts,
   input  lbbc_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output lbbc_pkg::rsp_type      rsp_data
);

   localparam int IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int TAG_W = lbbc_pkg::DEV_W + lbbc_pkg::BLK_W;

   lbbc_pkg::req_type req_ff;

   logic [IW-1:0] idx_ff, idx_in;

   logic [TAG_W-1:0]                tag_mem [SLOT_COUNT];
   logic [lbbc_pkg::COUNT_W-1:0]    cnt_mem [SLOT_COUNT];
   logic [lbbc_pkg::TIME_W-1:0]     use_mem [SLOT_COUNT];

   logic [SLOT_COUNT-1:0] tag_vld_ff, cnt_vld_ff, use_vld_ff, loaded_ff;

   logic [TAG_W-1:0]             tag_rd_ff;
   logic [lbbc_pkg::COUNT_W-1:0] cnt_rd_ff;
   logic [lbbc_pkg::TIME_W-1:0]  use_rd_ff;
   logic                         tag_vr_ff, cnt_vr_ff, use_vr_ff;
   logic [IW-1:0]                rd_idx_ff;
   logic                         cmp_ff;

   logic [TAG_W-1:0]             tag_eff;
   logic [lbbc_pkg::COUNT_W-1:0] cnt_eff;
   logic [lbbc_pkg::TIME_W-1:0]  use_eff;

   logic                         hit_fd_ff, free_fd_ff;
   logic [IW-1:0]                hit_idx_ff, best_idx_ff;
   logic [lbbc_pkg::COUNT_W-1:0] hit_cnt_ff;
   logic [lbbc_pkg::TIME_W-1:0]  best_use_ff;

   logic                         rd_en;
   logic [IW-1:0]                rd_addr, slot_idx, wr_addr;
   logic                         in_range;
   logic                         tag_we, cnt_we, use_we, set_loaded;
   logic [lbbc_pkg::COUNT_W-1:0] cnt_wd;
   lbbc_pkg::rsp_type            rsp_in, rsp_ff;
   logic                         rsp_vld_ff;

   assign slot_idx = IW'(req_ff.slot_in);
   assign in_range = 9'(req_ff.slot_in) < 9'(SLOT_COUNT);
   assign rd_en    = cmd.scan_rd | cmd.slot_rd;
   assign rd_addr  = cmd.scan_rd ? idx_ff : slot_idx;
   assign idx_in   = cmd.capture ? '0 : (cmd.scan_rd ? idx_ff + 1'b1 : idx_ff);

   assign tag_eff = tag_vr_ff ? tag_rd_ff : '0;
   assign cnt_eff = cnt_vr_ff ? cnt_rd_ff : '0;
   assign use_eff = use_vr_ff ? use_rd_ff : '0;

   assign sts.scan_last = (idx_ff == IW'(SLOT_COUNT - 1));
   assign sts.out_free  = !rsp_vld_ff || rsp_ready;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      tag_we     = 1'b0;
      cnt_we     = 1'b0;
      use_we     = 1'b0;
      set_loaded = 1'b0;
      wr_addr    = slot_idx;
      cnt_wd     = cnt_eff;
      rsp_in     = '{slot_out: req_ff.slot_in, hit: 1'b0, needs_read: 1'b0,
                     status: lbbc_pkg::ST_OK};
      if (req_ff.mode == lbbc_pkg::MODE_GET) begin
         if (hit_fd_ff) begin
            wr_addr         = hit_idx_ff;
            rsp_in.slot_out = lbbc_pkg::SLOT_W'(hit_idx_ff);
            rsp_in.hit      = 1'b1;
            if (hit_cnt_ff == lbbc_pkg::COUNT_MAX) begin
               rsp_in.status = lbbc_pkg::ST_OVER;
            end else begin
               cnt_we            = 1'b1;
               cnt_wd            = hit_cnt_ff + 1'b1;
               set_loaded        = 1'b1;
               rsp_in.needs_read = !loaded_ff[hit_idx_ff];
            end
         end else if (free_fd_ff) begin
            wr_addr           = best_idx_ff;
            tag_we            = 1'b1;
            cnt_we            = 1'b1;
            cnt_wd            = lbbc_pkg::COUNT_W'(1);
            set_loaded        = 1'b1;
            rsp_in.slot_out   = lbbc_pkg::SLOT_W'(best_idx_ff);
            rsp_in.needs_read = 1'b1;
         end else begin
            rsp_in.slot_out = '0;
            rsp_in.status   = lbbc_pkg::ST_NO_FREE;
         end
      end else if (in_range) begin
         if (req_ff.mode == lbbc_pkg::MODE_PIN) begin
            if (cnt_eff == lbbc_pkg::COUNT_MAX) begin
               rsp_in.status = lbbc_pkg::ST_OVER;
            end else begin
               cnt_we = 1'b1;
               cnt_wd = cnt_eff + 1'b1;
            end
         end else if (cnt_eff == '0) begin
            rsp_in.status = lbbc_pkg::ST_UNDER;
         end else begin
            cnt_we = 1'b1;
            cnt_wd = cnt_eff - 1'b1;
            use_we = (req_ff.mode == lbbc_pkg::MODE_RELEASE) &&
                     (cnt_eff == lbbc_pkg::COUNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         tag_rd_ff <= tag_mem[rd_addr];
         cnt_rd_ff <= cnt_mem[rd_addr];
         use_rd_ff <= use_mem[rd_addr];
      end
      if (cmd.update && tag_we) begin
         tag_mem[wr_addr] <= {req_ff.device, req_ff.block_number};
      end
      if (cmd.update && cnt_we) begin
         cnt_mem[wr_addr] <= cnt_wd;
      end
      if (cmd.update && use_we) begin
         use_mem[wr_addr] <= req_ff.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_vld_ff <= '0;
         cnt_vld_ff <= '0;
         use_vld_ff <= '0;
         loaded_ff  <= '0;
         rsp_vld_ff <= 1'b0;
         cmp_ff     <= 1'b0;
         idx_ff     <= '0;
         hit_fd_ff  <= 1'b0;
         free_fd_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         cmp_ff <= cmd.scan_rd;
         if (cmd.update) begin
            if (tag_we) tag_vld_ff[wr_addr] <= 1'b1;
            if (cnt_we) cnt_vld_ff[wr_addr] <= 1'b1;
            if (use_we) use_vld_ff[wr_addr] <= 1'b1;
            if (set_loaded) loaded_ff[wr_addr] <= 1'b1;
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
         if (cmd.capture) begin
            hit_fd_ff  <= 1'b0;
            free_fd_ff <= 1'b0;
         end else if (cmp_ff) begin
            if (!hit_fd_ff && tag_eff == {req_ff.device, req_ff.block_number}) begin
               hit_fd_ff <= 1'b1;
            end
            if (cnt_eff == '0 && (!free_fd_ff || use_eff < best_use_ff)) begin
               free_fd_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
      if (rd_en) begin
         rd_idx_ff <= rd_addr;
         tag_vr_ff <= tag_vld_ff[rd_addr];
         cnt_vr_ff <= cnt_vld_ff[rd_addr];
         use_vr_ff <= use_vld_ff[rd_addr];
      end
      if (cmp_ff && !cmd.capture) begin
         if (!hit_fd_ff && tag_eff == {req_ff.device, req_ff.block_number}) begin
            hit_idx_ff <= rd_idx_ff;
            hit_cnt_ff <= cnt_eff;
         end
         if (cnt_eff == '0 && (!free_fd_ff || use_eff < best_use_ff)) begin
            best_idx_ff <= rd_idx_ff;
            best_use_ff <= use_eff;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lbbc_controller.sv -----
// Controller state machine: sequences the accept, slot scan, slot read and update.
// Depends on lbbc_pkg; commands lbbc_datapath through cmd_type and sts_type.
`default_nettype none

module lbbc_controller (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_is_get,
   output logic               req_ready,
   output lbbc_pkg::cmd_type  cmd,
   input  lbbc_pkg::sts_type  sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_SLOT_RD,
      S_UPDATE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = req_is_get ? S_SCAN : S_SLOT_RD;
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_last) state_in = S_SCAN_END;
         end
         S_SCAN_END: begin
            state_in = S_UPDATE;
         end
         S_SLOT_RD: begin
            cmd.slot_rd = 1'b1;
            state_in    = S_UPDATE;
         end
         S_UPDATE: begin
            if (sts.out_free) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/sv/tb_lru_block_buffer_cache_core.sv -----
// Self-checking testbench for lru_block_buffer_cache_core: directed, fill, overflow and random
// traffic with random stalls on both channels, checked against an in-bench model of the cache.
// Depends on lbbc_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_lru_block_buffer_cache_core;

   localparam int SLOTS = 32;
   localparam int CYCLE_LIMIT = 1_000_000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lbbc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lbbc_pkg::rsp_type rsp_data;

   logic [lbbc_pkg::DEV_W-1:0]   tag_dev[SLOTS];
   logic [lbbc_pkg::BLK_W-1:0]   tag_blk[SLOTS];
   logic [lbbc_pkg::COUNT_W-1:0] use_count[SLOTS];
   logic [lbbc_pkg::TIME_W-1:0]  stamp[SLOTS];
   bit                           loaded[SLOTS];

   lbbc_pkg::rsp_type outcome_q[$];
   lbbc_pkg::rsp_type last_outcome;
   int      mismatches = 0;
   int      cycles_elapsed = 0;
   int      beats_sent = 0;
   int      n_hits = 0;
   int      n_fills = 0;
   int      n_no_free = 0;
   int      n_under = 0;
   int      n_over = 0;
   int      ready_hold = 0;
   bit      steady = 1'b0;

   lru_block_buffer_cache_core #(
      .SLOT_COUNT(SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tag_dev[i] = '0;
         tag_blk[i] = '0;
         use_count[i] = '0;
         stamp[i] = '0;
         loaded[i] = 1'b0;
      end
   end

   function automatic lbbc_pkg::rsp_type cache_outcome(input lbbc_pkg::req_type r);
      lbbc_pkg::rsp_type o;
      int      pick;
      int      s;
      o = '0;
      o.slot_out = r.slot_in;
      o.status = lbbc_pkg::ST_OK;
      s = int'(r.slot_in);
      case (r.mode)
         lbbc_pkg::MODE_GET: begin
            pick = -1;
            for (int i = 0; i < SLOTS; i++)
               if (pick < 0 && tag_dev[i] == r.device && tag_blk[i] == r.block_number)
                  pick = i;
            if (pick >= 0) begin
               o.slot_out = pick[lbbc_pkg::SLOT_W-1:0];
               o.hit = 1'b1;
               n_hits++;
               if (use_count[pick] == lbbc_pkg::COUNT_MAX) begin
                  o.status = lbbc_pkg::ST_OVER;
                  n_over++;
               end else begin
                  use_count[pick]++;
                  o.needs_read = !loaded[pick];
                  loaded[pick] = 1'b1;
               end
            end else begin
               for (int i = 0; i < SLOTS; i++)
                  if (use_count[i] == 0 && (pick < 0 || stamp[i] < stamp[pick]))
                     pick = i;
               if (pick < 0) begin
                  o.slot_out = '0;
                  o.status = lbbc_pkg::ST_NO_FREE;
                  n_no_free++;
               end else begin
                  tag_dev[pick] = r.device;
                  tag_blk[pick] = r.block_number;
                  use_count[pick] = lbbc_pkg::COUNT_W'(1);
                  loaded[pick] = 1'b1;
                  o.slot_out = pick[lbbc_pkg::SLOT_W-1:0];
                  o.needs_read = 1'b1;
                  n_fills++;
               end
            end
         end
         lbbc_pkg::MODE_PIN: begin
            if (use_count[s] == lbbc_pkg::COUNT_MAX) begin
               o.status = lbbc_pkg::ST_OVER;
               n_over++;
            end else begin
               use_count[s]++;
            end
         end
         default: begin
            if (use_count[s] == 0) begin
               o.status = lbbc_pkg::ST_UNDER;
               n_under++;
            end else begin
               use_count[s]--;
               if (r.mode == lbbc_pkg::MODE_RELEASE && use_count[s] == 0)
                  stamp[s] = r.now;
            end
         end
      endcase
      return o;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_slot(input bit held);
      int found[$];
      for (int i = 0; i < SLOTS; i++)
         if ((use_count[i] != 0) == held)
            found.push_back(i);
      if (found.size() == 0)
         return -1;
      return found[$urandom_range(0, found.size() - 1)];
   endfunction

   task automatic send_request(input lbbc_pkg::req_type r);
      int gap;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      last_outcome = cache_outcome(r);
      outcome_q.push_back(last_outcome);
      beats_sent++;
      if (!steady) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic issue_get(input logic [lbbc_pkg::DEV_W-1:0] dev,
                            input logic [lbbc_pkg::BLK_W-1:0] blk);
      lbbc_pkg::req_type r;
      r.mode = lbbc_pkg::MODE_GET;
      r.device = dev;
      r.block_number = blk;
      r.slot_in = lbbc_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
      r.now = $urandom;
      send_request(r);
   endtask

   task automatic issue_slot_op(input lbbc_pkg::mode_type m, input int slot,
                                input logic [lbbc_pkg::TIME_W-1:0] tick);
      lbbc_pkg::req_type r;
      r.mode = m;
      r.device = lbbc_pkg::DEV_W'($urandom);
      r.block_number = $urandom;
      r.slot_in = slot[lbbc_pkg::SLOT_W-1:0];
      r.now = tick;
      send_request(r);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (outcome_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic release_everything(input logic [lbbc_pkg::TIME_W-1:0] tick);
      for (int i = 0; i < SLOTS; i++)
         while (use_count[i] != 0)
            issue_slot_op(lbbc_pkg::MODE_RELEASE, i, tick);
   endtask

   // After reset every slot carries the tag of device 0, block 0, so the first gets alias.
   task automatic test_directed();
      issue_get(8'h00, 32'h0000_0000);
      issue_get(8'h00, 32'h0000_0000);
      issue_slot_op(lbbc_pkg::MODE_RELEASE, 0, 32'hFFFF_FFFF);
      issue_slot_op(lbbc_pkg::MODE_RELEASE, 0, 32'hFFFF_FFFF);
      issue_slot_op(lbbc_pkg::MODE_RELEASE, 0, 32'h0000_0000);
      issue_slot_op(lbbc_pkg::MODE_UNPIN, 5, 32'h0000_0000);
      issue_get(8'hFF, 32'hFFFF_FFFF);
      issue_slot_op(lbbc_pkg::MODE_PIN, 1, 32'h0000_0000);
      issue_slot_op(lbbc_pkg::MODE_UNPIN, 1, 32'hFFFF_FFFF);
      issue_slot_op(lbbc_pkg::MODE_RELEASE, 1, 32'h0000_0005);
      issue_slot_op(lbbc_pkg::MODE_PIN, 31, 32'hFFFF_FFFF);
      issue_slot_op(lbbc_pkg::MODE_UNPIN, 31, 32'h0000_0000);
      issue_slot_op(lbbc_pkg::MODE_UNPIN, 31, 32'h0000_0000);
      issue_get(8'h80, 32'h8000_0000);
      issue_get(8'hFF, 32'hFFFF_FFFF);
      issue_get(8'h01, 32'h0000_0001);
      issue_slot_op(lbbc_pkg::MODE_RELEASE, 1, 32'h8000_0000);
      issue_slot_op(lbbc_pkg::MODE_RELEASE, 2, 32'h0000_0001);
      issue_get(8'h7F, 32'h7FFF_FFFF);
      issue_get(8'h00, 32'h0000_0000);
      release_everything(32'h0000_0002);
      wait_until_idle();
   endtask

   // The receiver holds off while the sender starts to fill every slot, so the core backs up.
   task automatic test_no_free_slot();
      int n;
      wait_until_idle();
      n = 0;
      ready_hold = 400;
      while (pick_slot(1'b0) >= 0) begin
         issue_get(8'hA5, 32'hC000_0000 + n);
         n++;
      end
      issue_get(8'h5A, 32'hDEAD_BEEF);
      issue_get(8'hA5, 32'hC000_0000);
      issue_slot_op(lbbc_pkg::MODE_PIN, 7, 32'h0000_0000);
      release_everything(32'h0000_1234);
      issue_get(8'h5A, 32'hDEAD_BEEF);
      issue_get(8'h5B, 32'hDEAD_BEEF);
      release_everything(32'h0000_1235);
      wait_until_idle();
   endtask

   task automatic test_count_overflow();
      logic [lbbc_pkg::BLK_W-1:0] blk;
      int                         s;
      blk = $urandom;
      issue_get(8'h3C, blk);
      s = int'(last_outcome.slot_out);
      steady = 1'b1;
      while (use_count[s] != lbbc_pkg::COUNT_MAX)
         issue_slot_op(lbbc_pkg::MODE_PIN, s, $urandom);
      steady = 1'b0;
      issue_slot_op(lbbc_pkg::MODE_PIN, s, $urandom);
      issue_get(8'h3C, blk);
      issue_slot_op(lbbc_pkg::MODE_UNPIN, s, $urandom);
      issue_get(8'h3C, blk);
      issue_get(8'h3C, blk);
      release_everything($urandom);
      wait_until_idle();
   endtask

   task automatic test_random_traffic(input int count);
      logic [lbbc_pkg::DEV_W-1:0]  pool_dev[16];
      logic [lbbc_pkg::BLK_W-1:0]  pool_blk[16];
      logic [lbbc_pkg::TIME_W-1:0] tick;
      lbbc_pkg::req_type           r;
      int                          roll;
      int                          k;
      int                          s;
      for (int i = 0; i < 16; i++) begin
         pool_dev[i] = lbbc_pkg::DEV_W'($urandom);
         pool_blk[i] = $urandom;
      end
      tick = $urandom_range(0, 1000);
      for (k = 0; k < count; k++) begin
         steady = (k >= count / 2 && k < count / 2 + 80);
         if (k == count / 3)
            wait_until_idle();
         if ($urandom_range(0, 9) == 0) begin
            s = $urandom_range(0, 15);
            pool_dev[s] = lbbc_pkg::DEV_W'($urandom);
            pool_blk[s] = $urandom;
         end
         tick += $urandom_range(0, 50);
         roll = $urandom_range(0, 99);
         s = pick_slot(1'b1);
         if (s < 0)
            s = $urandom_range(0, SLOTS - 1);
         if (roll < 40) begin
            if ($urandom_range(0, 9) < 7) begin
               s = $urandom_range(0, 15);
               issue_get(pool_dev[s], pool_blk[s]);
            end else begin
               issue_get(lbbc_pkg::DEV_W'($urandom), $urandom);
            end
         end else if (roll < 70) begin
            issue_slot_op(lbbc_pkg::MODE_RELEASE, s,
                          ($urandom_range(0, 19) == 0) ? $urandom : tick);
         end else if (roll < 80) begin
            issue_slot_op(lbbc_pkg::MODE_PIN, s, tick);
         end else if (roll < 90) begin
            issue_slot_op(lbbc_pkg::MODE_UNPIN, s, tick);
         end else begin
            r.mode = lbbc_pkg::mode_type'($urandom_range(0, 3));
            r.device = lbbc_pkg::DEV_W'($urandom);
            r.block_number = $urandom;
            r.slot_in = lbbc_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
            r.now = $urandom;
            send_request(r);
         end
      end
      steady = 1'b0;
      wait_until_idle();
   endtask

   initial begin
      int stall;
      int open;
      forever begin
         if (ready_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (ready_hold) @(posedge clock);
            ready_hold = 0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            open = $urandom_range(1, 12);
            repeat (open) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      lbbc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_q.size() == 0) begin
            $error("unexpected response beat: slot_out %0d status %0d",
                   rsp_data.slot_out, rsp_data.status);
            mismatches++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_data.slot_out !== want.slot_out) begin
               $error("slot_out: expected %0d, got %0d", want.slot_out, rsp_data.slot_out);
               mismatches++;
            end
            if (rsp_data.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_data.hit);
               mismatches++;
            end
            if (rsp_data.needs_read !== want.needs_read) begin
               $error("needs_read: expected %0d, got %0d", want.needs_read,
                      rsp_data.needs_read);
               mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock)
      cycles_elapsed <= cycles_elapsed + 1;

   initial begin
      while (cycles_elapsed < CYCLE_LIMIT)
         @(posedge clock);
      $display("Timed out after %0d cycles with %0d responses outstanding.", cycles_elapsed,
               outcome_q.size());
      $display("lru_block_buffer_cache_core regression: fail");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_no_free_slot();
      test_count_overflow();
      test_random_traffic(650);
      repeat (SLOTS * 2 + 20) @(posedge clock);
      $display("Sent %0d request beats: %0d get hits, %0d fills, %0d with no free slot.",
               beats_sent, n_hits, n_fills, n_no_free);
      $display("Saw %0d count underflows, %0d count overflows and %0d mismatches.",
               n_under, n_over, mismatches);
      if (mismatches == 0)
         $display("lru_block_buffer_cache_core regression: pass");
      else
         $display("lru_block_buffer_cache_core regression: fail");
      $finish;
   end

endmodule
